// File: rtl/kef_pkg.sv
// ---------------------------------------------------------------------------
// kef_pkg - shared types and constants for the keyboard event queue
// Request codes, field widths and beat layouts used by the queue and its testbench.
// ---------------------------------------------------------------------------
package kef_pkg;

    localparam int REQ_W    = 2;
    localparam int SCAN_W   = 8;
    localparam int TICK_W   = 32;
    localparam int FILL_W   = 6;
    localparam int ENTRY_W  = SCAN_W + TICK_W;
    localparam int S_DATA_W = SCAN_W + TICK_W;
    localparam int M_DATA_W = SCAN_W + 1 + TICK_W + FILL_W + 1;

    // bit of the scancode that marks a key release
    localparam int RELEASE_BIT = 7;

    typedef logic [REQ_W-1:0] req_t;

    localparam req_t REQ_PUSH  = 2'd0;
    localparam req_t REQ_POP   = 2'd1;
    localparam req_t REQ_FLUSH = 2'd2;

endpackage

// File: rtl/kef_ram.sv
// ---------------------------------------------------------------------------
// kef_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without rd_en.
// ---------------------------------------------------------------------------
module kef_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/key_event_fifo_drop_oldest.sv
// ---------------------------------------------------------------------------
// key_event_fifo_drop_oldest - keyboard event queue with drop-oldest overflow
// Circular event store in RAM with read/write pointers and a fill count.
// ---------------------------------------------------------------------------
// Usage:
//   s_ beat: tuser carries the request (push, pop, flush), tdata the scancode
//   and the tick stamp for a push. Every request beat gives exactly one m_
//   result beat: pop data with event_valid in tuser, the fill count after the
//   request, and a flag set when a push into a full queue dropped the oldest
//   event. A push is never refused.
//   The result appears in the cycle after acceptance, with the popped entry
//   coming straight from the RAM's registered read port.
//   Throughput is one request per cycle while the receiver takes each result,
//   set by the single RAM read port and the pointer update that each request completes before the next.
//   The RAM read register and the result flags form the output stage; s_tready
//   stays high while that stage is empty or being taken, so a stalled receiver
//   holds the result and blocks further requests until it is taken.
//   Reset empties the queue (pointers and count to zero) and drops any pending
//   result; the RAM contents are not cleared, no request can read a slot that
//   was never pushed.
// ---------------------------------------------------------------------------
module key_event_fifo_drop_oldest #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [kef_pkg::S_DATA_W-1:0]  s_tdata,  // scancode_in, tick_in
    input  kef_pkg::req_t                 s_tuser,  // req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [kef_pkg::M_DATA_W-1:0]  m_tdata,  // event_scancode, event_pressed,
                                                    // event_time, fill_count,
                                                    // dropped_oldest
    output logic                          m_tuser   // event_valid
);
    import kef_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              out_valid_reg;
    logic              ev_valid_reg, ev_valid_next;
    logic              dropped_reg, dropped_next;
    logic [FILL_W-1:0] fill_reg;

    logic              accept;
    logic              full;
    logic              empty;
    logic              do_push;
    logic              do_pop;
    logic [ENTRY_W-1:0] rd_entry;
    logic [SCAN_W-1:0] ev_scan;
    logic [TICK_W-1:0] ev_tick;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_push  = accept && (s_tuser == REQ_PUSH);
    assign do_pop   = accept && (s_tuser == REQ_POP) && !empty;

    always_comb begin
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        count_next    = count_reg;
        ev_valid_next = 1'b0;
        dropped_next  = 1'b0;
        if (accept) begin
            case (s_tuser)
                REQ_PUSH: begin
                    wr_ptr_next = ptr_inc(wr_ptr_reg);
                    if (full) begin
                        // overwrite the oldest slot, count stays at depth
                        rd_ptr_next  = ptr_inc(rd_ptr_reg);
                        dropped_next = 1'b1;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                REQ_POP: begin
                    if (!empty) begin
                        rd_ptr_next   = ptr_inc(rd_ptr_reg);
                        count_next    = count_reg - CNT_W'(1);
                        ev_valid_next = 1'b1;
                    end
                end
                REQ_FLUSH: begin
                    rd_ptr_next = '0;
                    wr_ptr_next = '0;
                    count_next  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ev_valid_reg <= ev_valid_next;
            dropped_reg  <= dropped_next;
            fill_reg     <= FILL_W'(count_next);
        end
    end

    kef_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (do_push),
        .wr_addr (wr_ptr_reg),
        .wr_data (s_tdata),
        .rd_en   (do_pop),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_entry)
    );

    // event fields read as zero unless a pop returned an event
    assign ev_scan = ev_valid_reg ? rd_entry[SCAN_W-1:0] : '0;
    assign ev_tick = ev_valid_reg ? rd_entry[ENTRY_W-1:SCAN_W] : '0;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = ev_valid_reg;
    assign m_tdata  = {dropped_reg, fill_reg, ev_tick,
                       ev_valid_reg && !ev_scan[RELEASE_BIT], ev_scan};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("fill count above queue depth");

    a_ptr_meet: assert property (@(posedge aclk) disable iff (!aresetn)
        (empty || full) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("pointers disagree with empty or full count");

    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && full) |=> (count_reg == CNT_FULL) && dropped_reg)
        else $error("push into full queue did not keep it full and flag drop");

    a_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tuser == REQ_FLUSH)) |=>
            (count_reg == '0) && (rd_ptr_reg == '0) && (wr_ptr_reg == '0))
        else $error("flush did not empty the queue");

endmodule

// File: sim/key_event_fifo_drop_oldest_test.sv
// ---------------------------------------------------------------------------
// key_event_fifo_drop_oldest_test - testbench for the keyboard event queue
// Drives push, pop, flush and unused requests into the queue. The sender
// works in bursts and the receiver stalls on its own pattern. A behavioral
// queue predicts every result beat, and each beat is compared field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_event_fifo_drop_oldest_test;
    import kef_pkg::*;

    localparam int   DEPTH       = 32;
    localparam int   CYCLE_LIMIT = 400000;
    localparam req_t REQ_UNUSED  = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [SCAN_W-1:0] scancode;
        logic              pressed;
        logic [TICK_W-1:0] stamp;
        logic [FILL_W-1:0] fill;
        logic              dropped;
    } key_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    req_t                s_tuser  = REQ_PUSH;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;

    key_event_fifo_drop_oldest #(
        .QUEUE_DEPTH(DEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // scancode_in, tick_in
        .s_tuser (s_tuser),   // req_type
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),   // event_scancode, event_pressed, event_time,
                              // fill_count, dropped_oldest
        .m_tuser (m_tuser)    // event_valid
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // queue model state
    logic [SCAN_W-1:0] model_code  [DEPTH];
    logic [TICK_W-1:0] model_stamp [DEPTH];
    int                model_rd;
    int                model_wr;
    int                model_held;

    key_result_t pending_results[$];

    int error_count   = 0;
    int cycle_count   = 0;
    int beats_sent    = 0;
    int pushes_seen   = 0;
    int events_popped = 0;
    int empty_pops    = 0;
    int drops_seen    = 0;
    int flushes_seen  = 0;
    int unused_seen   = 0;
    int full_hits     = 0;

    // idle shaping, changed by the tests
    int stall_max   = 0;
    int ready_max   = 0;
    int gap_max     = 0;
    int burst_max   = 1;
    int ready_left  = 0;
    int burst_left  = 0;

    task automatic model_request(input req_t req, input logic [SCAN_W-1:0] code,
                                 input logic [TICK_W-1:0] stamp,
                                 output key_result_t res);
        res = '0;
        case (req)
            REQ_PUSH: begin
                if (model_held >= DEPTH) begin
                    model_rd    = (model_rd + 1) % DEPTH;
                    model_held  = DEPTH - 1;
                    res.dropped = 1'b1;
                end
                model_code[model_wr]  = code;
                model_stamp[model_wr] = stamp;
                model_wr   = (model_wr + 1) % DEPTH;
                model_held = model_held + 1;
            end
            REQ_POP: begin
                if (model_held > 0) begin
                    res.valid    = 1'b1;
                    res.scancode = model_code[model_rd];
                    res.pressed  = ~model_code[model_rd][RELEASE_BIT];
                    res.stamp    = model_stamp[model_rd];
                    model_rd     = (model_rd + 1) % DEPTH;
                    model_held   = model_held - 1;
                end
            end
            REQ_FLUSH: begin
                model_rd   = 0;
                model_wr   = 0;
                model_held = 0;
            end
            default: ;
        endcase
        res.fill = model_held[FILL_W-1:0];
    endtask

    function automatic void check_field(input string name, input logic [TICK_W-1:0] want,
                                        input logic [TICK_W-1:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endfunction

    // result check first, then prediction for the beat taken at this edge
    always @(posedge aclk) begin
        key_result_t want;
        key_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.valid    = m_tuser;
            got.scancode = m_tdata[SCAN_W-1:0];
            got.pressed  = m_tdata[SCAN_W];
            got.stamp    = m_tdata[SCAN_W+1 +: TICK_W];
            got.fill     = m_tdata[SCAN_W+1+TICK_W +: FILL_W];
            got.dropped  = m_tdata[M_DATA_W-1];
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: result beat with nothing expected, expected none, actual 0x%0h",
                         $time, m_tdata);
            end else begin
                want = pending_results.pop_front();
                check_field("event_valid",    TICK_W'(want.valid),    TICK_W'(got.valid));
                check_field("event_scancode", TICK_W'(want.scancode), TICK_W'(got.scancode));
                check_field("event_pressed",  TICK_W'(want.pressed),  TICK_W'(got.pressed));
                check_field("event_time",     want.stamp,             got.stamp);
                check_field("fill_count",     TICK_W'(want.fill),     TICK_W'(got.fill));
                check_field("dropped_oldest", TICK_W'(want.dropped),  TICK_W'(got.dropped));
                if (want.dropped)
                    drops_seen++;
                if (want.valid)
                    events_popped++;
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            case (s_tuser)
                REQ_PUSH:  pushes_seen++;
                REQ_POP:   if (model_held == 0) empty_pops++;
                REQ_FLUSH: flushes_seen++;
                default:   unused_seen++;
            endcase
            model_request(s_tuser, s_tdata[SCAN_W-1:0], s_tdata[SCAN_W +: TICK_W], want);
            if (model_held == DEPTH)
                full_hits++;
            pending_results.push_back(want);
        end
    end

    // receiver: alternating runs of ready and stall
    always @(negedge aclk) begin
        if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else if (stall_max != 0 && m_tready) begin
            m_tready   <= 1'b0;
            ready_left <= $urandom_range(0, stall_max - 1);
        end else begin
            m_tready   <= 1'b1;
            ready_left <= $urandom_range(0, ready_max);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // one request beat, then a gap if the current burst is used up and gap_max is nonzero
    task automatic send_beat(input req_t req, input logic [SCAN_W-1:0] code,
                             input logic [TICK_W-1:0] stamp);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {stamp, code};
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, burst_max);
            if (gap_max > 0) begin
                gap = $urandom_range(1, gap_max);
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    task automatic wait_all_done();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [TICK_W-1:0] pick_stamp();
        int r;
        r = $urandom_range(0, 15);
        if (r < 2)
            return '0;
        if (r == 2)
            return '1;
        return $urandom;
    endfunction

    function automatic logic [SCAN_W-1:0] pick_code();
        return SCAN_W'($urandom_range(0, 255));
    endfunction

    function automatic void set_idling(input int stall, input int ready, input int gap,
                                       input int burst);
        stall_max = stall;
        ready_max = ready;
        gap_max   = gap;
        burst_max = burst;
    endfunction

    task automatic test_field_extremes();
        set_idling(3, 4, 2, 4);
        send_beat(REQ_PUSH, 8'h00, 32'h0000_0000);
        send_beat(REQ_PUSH, 8'hFF, 32'hFFFF_FFFF);
        send_beat(REQ_PUSH, 8'h80, 32'h8000_0000);
        send_beat(REQ_PUSH, 8'h7F, 32'h0000_0001);
        send_beat(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF);
        repeat (4) send_beat(REQ_POP, 8'h00, 32'h0);
        // pop with nothing held
        send_beat(REQ_POP, 8'hFF, 32'hFFFF_FFFF);
        send_beat(REQ_UNUSED, 8'h00, 32'h0);
        send_beat(REQ_PUSH, 8'h1C, 32'h1234_5678);
        send_beat(REQ_FLUSH, 8'hAA, 32'hAAAA_AAAA);
        send_beat(REQ_POP, 8'h00, 32'h0);
        send_beat(REQ_PUSH, 8'hAA, 32'hAAAA_AAAA);
        send_beat(REQ_PUSH, 8'h55, 32'h5555_5555);
        send_beat(REQ_POP, 8'h00, 32'h0);
        send_beat(REQ_POP, 8'h00, 32'h0);
        wait_all_done();
    endtask

    task automatic test_overflow_drop();
        set_idling(0, 0, 0, 1);
        repeat (DEPTH) send_beat(REQ_PUSH, pick_code(), pick_stamp());
        // full from here on: each push drops the oldest
        repeat (5) send_beat(REQ_PUSH, pick_code(), pick_stamp());
        set_idling(6, 3, 3, 8);
        repeat (DEPTH + 1) send_beat(REQ_POP, pick_code(), pick_stamp());
        wait_all_done();
    endtask

    task automatic test_flush_midway();
        set_idling(2, 6, 1, 10);
        repeat (20) send_beat(REQ_PUSH, pick_code(), pick_stamp());
        send_beat(REQ_FLUSH, pick_code(), pick_stamp());
        repeat (DEPTH + 8) send_beat(REQ_PUSH, pick_code(), pick_stamp());
        repeat (10) send_beat(REQ_POP, pick_code(), pick_stamp());
        send_beat(REQ_FLUSH, pick_code(), pick_stamp());
        send_beat(REQ_POP, pick_code(), pick_stamp());
        wait_all_done();
    endtask

    task automatic test_random_traffic(input int beats);
        int   push_pct;
        int   r;
        int   n;
        req_t req;
        push_pct = 50;
        for (n = 0; n < beats; n++) begin
            if (n % 60 == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 85;
                    1:       push_pct = 50;
                    default: push_pct = 15;
                endcase
                case ($urandom_range(0, 3))
                    0:       set_idling(0, 0, 0, 1);
                    1:       set_idling(4, 4, 3, 6);
                    2:       set_idling(12, 2, 6, 3);
                    default: set_idling(1, 10, 1, 20);
                endcase
            end
            if (n == beats / 2)
                wait_all_done();
            r = $urandom_range(0, 99);
            if (r < 2)
                req = REQ_FLUSH;
            else if (r < 4)
                req = REQ_UNUSED;
            else if (r < 4 + push_pct * 96 / 100)
                req = REQ_PUSH;
            else
                req = REQ_POP;
            send_beat(req, pick_code(), pick_stamp());
        end
        wait_all_done();
    endtask

    initial begin
        model_rd   = 0;
        model_wr   = 0;
        model_held = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        test_field_extremes();
        test_overflow_drop();
        test_flush_midway();
        test_random_traffic(1500);
        repeat (10) @(posedge aclk);
        $display("covered %0d beats: %0d pushes, %0d events popped, %0d empty pops,",
                 beats_sent, pushes_seen, events_popped, empty_pops);
        $display("%0d drops on full, %0d flushes, %0d unused requests, full %0d times",
                 drops_seen, flushes_seen, unused_seen, full_hits);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: key_event_fifo_drop_oldest.f
rtl/kef_pkg.sv
rtl/kef_ram.sv
rtl/key_event_fifo_drop_oldest.sv
sim/key_event_fifo_drop_oldest_test.sv
